>>> hw/rtl/rwps_pkg.sv
// ============================================================================
// rwps_pkg
// Shared constants, types and register codes of the point smoother.
// ============================================================================
`default_nettype none

package rwps_pkg;

    localparam int NUM_CHANNELS      = 46;
    localparam int KEYPOINT_CHANNELS = 42;
    localparam int WARMUP_FRAMES     = 5;
    localparam int HIST_DEPTH        = 4;

    localparam int CH_W       = 6;
    localparam int SAMPLE_W   = 24;
    localparam int WEIGHT_W   = 16;
    localparam int NUM_WEIGHTS = HIST_DEPTH + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int SLOT_W     = 2;
    localparam int FRAMES_W   = 3;

    // Signed sample times unsigned weight, then the sum of five products.
    localparam int PROD_W      = SAMPLE_W + WEIGHT_W + 1;
    localparam int ACC_W       = PROD_W + 3;
    localparam int ROUND_SHIFT = WEIGHT_W;
    localparam int BOX_SHIFT   = WEIGHT_W + 8;
    localparam int PIXEL_SHIFT = 8;
    localparam int SAT_W       = ACC_W - ROUND_SHIFT;

    localparam int DATA_BITS = CH_W + SAMPLE_W;
    localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8;
    localparam int PAD_W     = TDATA_W - DATA_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_OLDEST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_THIRD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SECOND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_PREVIOUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CURRENT  = 3'd4;

    typedef logic signed [SAMPLE_W-1:0]               sample_t;
    typedef logic [WEIGHT_W-1:0]                      weight_t;
    typedef logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0]     weight_set_t;
    typedef logic [HIST_DEPTH-1:0][SAMPLE_W-1:0]      hist_row_t;

    localparam weight_set_t WEIGHT_RESET = {16'd45875, 16'd13107, 16'd6554, 16'd0, 16'd0};

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        sample_t           sample;
        logic              frame_end;
        logic              warm;
        logic              box;
        logic [SLOT_W-1:0] ring;
    } item_t;

    typedef struct packed {
        logic                warm;
        logic [SLOT_W-1:0]   ring;
        logic [FRAMES_W-1:0] frames;
    } frame_state_t;

    typedef struct packed {
        logic              wr_en;
        logic [CH_W-1:0]   ch;
        logic [SLOT_W-1:0] slot;
        sample_t           data;
    } hist_wr_t;

endpackage

`default_nettype wire

>>> hw/rtl/rwps_hist_mem.sv
// ============================================================================
// rwps_hist_mem
// History memory: one row of four stored results per channel, one row read
// per cycle with registered data, one slot written per cycle.
// ============================================================================
`default_nettype none

module rwps_hist_mem (
    input  wire logic                      clk,
    input  wire logic                      rd_en,
    input  wire logic [rwps_pkg::CH_W-1:0] rd_ch,
    input  wire rwps_pkg::hist_wr_t        wr,
    output rwps_pkg::hist_row_t            rd_data
);

    rwps_pkg::hist_row_t mem [0:rwps_pkg::NUM_CHANNELS-1];
    rwps_pkg::hist_row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            mem[wr.ch][wr.slot] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_ch];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rwps_frame_ctrl.sv
// ============================================================================
// rwps_frame_ctrl
// Frame counter and ring position of the history, with restart.
// ============================================================================
`default_nettype none

module rwps_frame_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic               restart,
    input  wire logic               frame_end,
    output rwps_pkg::frame_state_t  state
);

    localparam int FRAMES_W = rwps_pkg::FRAMES_W;
    localparam logic [FRAMES_W-1:0] WARMUP = FRAMES_W'(rwps_pkg::WARMUP_FRAMES);

    logic [FRAMES_W-1:0]         frames_reg;
    logic [FRAMES_W-1:0]         frames_next;
    logic [rwps_pkg::SLOT_W-1:0] ring_reg;
    logic [rwps_pkg::SLOT_W-1:0] ring_next;
    logic                        warm;

    assign warm = frames_reg < WARMUP;

    always_comb
    begin
        frames_next = frames_reg;
        ring_next   = ring_reg;
        if (step)
        begin
            if (restart)
            begin
                frames_next = '0;
                ring_next   = '0;
            end
            else if (frame_end)
            begin
                ring_next = ring_reg + 1'b1;
                if (warm)
                begin
                    frames_next = frames_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= '0;
            ring_reg   <= '0;
        end
        else
        begin
            frames_reg <= frames_next;
            ring_reg   <= ring_next;
        end
    end

    assign state.warm   = warm;
    assign state.ring   = ring_reg;
    assign state.frames = frames_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rwps_pipe.sv
// ============================================================================
// rwps_pipe
// Weighting pipeline: products, sum, rounding and saturation (bypassed in
// warm-up), history write back, output register; stages advance on their own.
// ============================================================================
`default_nettype none

module rwps_pipe (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_load,
    input  wire rwps_pkg::item_t           in_item,
    input  wire logic [rwps_pkg::CH_W-1:0] in_ch,
    input  wire rwps_pkg::weight_set_t     weights,
    input  wire rwps_pkg::hist_row_t       rd_data,
    input  wire logic                      out_ready,
    output logic                           can_load,
    output logic                           in_conflict,
    output rwps_pkg::hist_wr_t             wr,
    output logic                           out_valid,
    output logic [rwps_pkg::CH_W-1:0]      out_channel,
    output rwps_pkg::sample_t              smoothed,
    output logic                           out_frame_end,
    output logic                           warming_up
);

    localparam int SLOT_W      = rwps_pkg::SLOT_W;
    localparam int PROD_W      = rwps_pkg::PROD_W;
    localparam int ACC_W       = rwps_pkg::ACC_W;
    localparam int SAT_W       = rwps_pkg::SAT_W;
    localparam int HIST_DEPTH  = rwps_pkg::HIST_DEPTH;
    localparam int NUM_WEIGHTS = rwps_pkg::NUM_WEIGHTS;
    localparam int ROUND_SHIFT = rwps_pkg::ROUND_SHIFT;
    localparam int BOX_SHIFT   = rwps_pkg::BOX_SHIFT;
    localparam int PIXEL_SHIFT = rwps_pkg::PIXEL_SHIFT;
    localparam int SAMPLE_W    = rwps_pkg::SAMPLE_W;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (ROUND_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] BOX_BIAS   = (ACC_W'(1) << BOX_SHIFT) - 1'b1;
    localparam rwps_pkg::sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam rwps_pkg::sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(SAMPLE_MAX);
    localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(SAMPLE_MIN);

    function automatic rwps_pkg::sample_t saturate(input logic signed [SAT_W-1:0] v);
        rwps_pkg::sample_t r;
        if (v > SAT_HI)
        begin
            r = SAMPLE_MAX;
        end
        else if (v < SAT_LO)
        begin
            r = SAMPLE_MIN;
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    logic                 s1_valid_reg;
    rwps_pkg::item_t      s1_item_reg;
    logic                 s2_valid_reg;
    rwps_pkg::item_t      s2_item_reg;
    logic signed [PROD_W-1:0] s2_prod_reg [NUM_WEIGHTS];
    logic                 s3_valid_reg;
    rwps_pkg::item_t      s3_item_reg;
    logic signed [ACC_W-1:0]  s3_acc_reg;
    logic                 out_valid_reg;
    rwps_pkg::item_t      out_item_reg;
    rwps_pkg::sample_t    out_data_reg;

    logic en0;
    logic en1;
    logic en2;
    logic en3;

    rwps_pkg::sample_t        hist_tap [HIST_DEPTH];
    logic signed [PROD_W-1:0] prod [NUM_WEIGHTS];
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [ACC_W-1:0]  key_sum;
    logic signed [ACC_W-1:0]  box_sum;
    logic signed [SAT_W-1:0]  key_val;
    logic signed [SAT_W-1:0]  box_val;
    rwps_pkg::sample_t        result;

    assign en3 = !out_valid_reg || out_ready;
    assign en2 = !s3_valid_reg || en3;
    assign en1 = !s2_valid_reg || en2;
    assign en0 = !s1_valid_reg || en1;

    assign can_load    = en0;
    assign in_conflict = (s1_valid_reg && (s1_item_reg.channel == in_ch))
                      || (s2_valid_reg && (s2_item_reg.channel == in_ch))
                      || (s3_valid_reg && (s3_item_reg.channel == in_ch));

    // Weight k pairs with the slot k places after the oldest one.
    for (genvar k = 0; k < HIST_DEPTH; k++)
    begin : g_tap
        assign hist_tap[k] = rd_data[s1_item_reg.ring + SLOT_W'(k)];
        assign prod[k]     = hist_tap[k] * $signed({1'b0, weights[k]});
    end
    assign prod[HIST_DEPTH] = s1_item_reg.sample * $signed({1'b0, weights[HIST_DEPTH]});

    always_comb
    begin
        acc_sum = '0;
        for (int k = 0; k < NUM_WEIGHTS; k++)
        begin
            acc_sum = acc_sum + ACC_W'(s2_prod_reg[k]);
        end
    end

    assign key_sum = s3_acc_reg + ROUND_HALF;
    assign key_val = key_sum[ACC_W-1:ROUND_SHIFT];
    assign box_sum = s3_acc_reg + (s3_acc_reg[ACC_W-1] ? BOX_BIAS : '0);
    assign box_val = {box_sum[ACC_W-1:BOX_SHIFT], {PIXEL_SHIFT{1'b0}}};

    always_comb
    begin
        if (s3_item_reg.warm)
        begin
            result = s3_item_reg.sample;
        end
        else if (s3_item_reg.box)
        begin
            result = saturate(box_val);
        end
        else
        begin
            result = saturate(key_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                s1_valid_reg <= in_load;
            end
            if (en1)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en2)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en3)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0 && in_load)
        begin
            s1_item_reg <= in_item;
        end
        if (en1 && s1_valid_reg)
        begin
            s2_item_reg <= s1_item_reg;
            for (int k = 0; k < NUM_WEIGHTS; k++)
            begin
                s2_prod_reg[k] <= prod[k];
            end
        end
        if (en2 && s2_valid_reg)
        begin
            s3_item_reg <= s2_item_reg;
            s3_acc_reg  <= acc_sum;
        end
        if (en3 && s3_valid_reg)
        begin
            out_item_reg <= s3_item_reg;
            out_data_reg <= result;
        end
    end

    assign wr.wr_en = en3 && s3_valid_reg;
    assign wr.ch    = s3_item_reg.channel;
    assign wr.slot  = s3_item_reg.ring;
    assign wr.data  = result;

    assign out_valid     = out_valid_reg;
    assign out_channel   = out_item_reg.channel;
    assign smoothed      = out_data_reg;
    assign out_frame_end = out_item_reg.frame_end;
    assign warming_up    = out_item_reg.warm;

endmodule

`default_nettype wire

>>> hw/rtl/recursive_weighted_point_smoother.sv
// ============================================================================
// recursive_weighted_point_smoother
// Smooths a multichannel coordinate stream with a weighted sum of each
// channel's four previous results and the new sample.
// ============================================================================
// Path: an accepted item is registered in s1, s2 and s3, then in the output
// register. Throughput: one item per cycle unless m_tready stalls; an item
// whose channel is still in the three-stage weighting pipeline waits until
// that write has reached the history memory.
// Reset: weights take their default values, frame count and ring position
// clear; history contents stay undefined and are not cleared.
`default_nettype none

module recursive_weighted_point_smoother (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // channel [5:0], sample [29:6], zero [31:30]
    input  wire logic [rwps_pkg::TDATA_W-1:0]        s_tdata,
    // action
    input  wire logic                                s_tuser,
    input  wire logic                                s_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // out_channel [5:0], smoothed [29:6], zero [31:30]
    output logic [rwps_pkg::TDATA_W-1:0]             m_tdata,
    // warming_up
    output logic                                     m_tuser,
    output logic                                     m_tlast,
    input  wire logic                                cfg_we,
    input  wire logic [rwps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rwps_pkg::WEIGHT_W-1:0]       cfg_data
);

    localparam int CH_W     = rwps_pkg::CH_W;
    localparam int SAMPLE_W = rwps_pkg::SAMPLE_W;

    rwps_pkg::weight_set_t  weights_reg;
    rwps_pkg::frame_state_t frame_st;
    rwps_pkg::item_t        in_item;
    rwps_pkg::hist_wr_t     hist_wr;
    rwps_pkg::hist_row_t    rd_data;
    rwps_pkg::sample_t      smoothed;

    logic [CH_W-1:0]               in_ch;
    logic                          in_action;
    logic                          produces;
    logic                          can_load;
    logic                          in_conflict;
    logic                          accept;
    logic                          in_load;
    logic [CH_W-1:0]               out_channel;
    logic [rwps_pkg::FRAMES_W-1:0] frames_inc;

    assign in_ch     = s_tdata[CH_W-1:0];
    assign in_action = s_tuser;
    assign produces  = !in_action && (in_ch < CH_W'(rwps_pkg::NUM_CHANNELS));

    assign s_tready = can_load && !(produces && in_conflict);
    assign accept   = s_tvalid && s_tready;
    assign in_load  = accept && produces;

    assign in_item.channel   = in_ch;
    assign in_item.sample    = s_tdata[CH_W +: SAMPLE_W];
    assign in_item.frame_end = s_tlast;
    assign in_item.warm      = frame_st.warm;
    assign in_item.box       = in_ch >= CH_W'(rwps_pkg::KEYPOINT_CHANNELS);
    assign in_item.ring      = frame_st.ring;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg <= rwps_pkg::WEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rwps_pkg::REG_WEIGHT_OLDEST:   weights_reg[0] <= cfg_data;
                rwps_pkg::REG_WEIGHT_THIRD:    weights_reg[1] <= cfg_data;
                rwps_pkg::REG_WEIGHT_SECOND:   weights_reg[2] <= cfg_data;
                rwps_pkg::REG_WEIGHT_PREVIOUS: weights_reg[3] <= cfg_data;
                rwps_pkg::REG_WEIGHT_CURRENT:  weights_reg[4] <= cfg_data;
                default:                       weights_reg    <= weights_reg;
            endcase
        end
    end

    rwps_frame_ctrl u_frame_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .restart   (in_action),
        .frame_end (s_tlast),
        .state     (frame_st)
    );

    rwps_hist_mem u_hist_mem (
        .clk     (clk),
        .rd_en   (in_load),
        .rd_ch   (in_ch),
        .wr      (hist_wr),
        .rd_data (rd_data)
    );

    rwps_pipe u_pipe (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_load       (in_load),
        .in_item       (in_item),
        .in_ch         (in_ch),
        .weights       (weights_reg),
        .rd_data       (rd_data),
        .out_ready     (m_tready),
        .can_load      (can_load),
        .in_conflict   (in_conflict),
        .wr            (hist_wr),
        .out_valid     (m_tvalid),
        .out_channel   (out_channel),
        .smoothed      (smoothed),
        .out_frame_end (m_tlast),
        .warming_up    (m_tuser)
    );

    assign m_tdata = {{rwps_pkg::PAD_W{1'b0}}, smoothed, out_channel};

    assign frames_inc = frame_st.frames + 1'b1;

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_action) |=> (frame_st.frames == '0 && frame_st.ring == '0))
        else $error("restart did not clear the frame state");

    a_no_read_of_pending_write: assert property (@(posedge clk) disable iff (!rst_n)
        (hist_wr.wr_en && in_load) |-> (hist_wr.ch != in_ch))
        else $error("history read of a channel whose write is still pending");

    a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_action && s_tlast && frame_st.warm)
            |=> (frame_st.frames == $past(frames_inc)))
        else $error("frame end during warm-up did not advance the frame count");

endmodule

`default_nettype wire
